FILE: rtl/tlc_pkg.sv
`default_nettype none
package tlc_pkg;

  localparam int TICKS_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int LIGHT_W    = 2;

  typedef logic [TICKS_W-1:0]   ticks_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [LIGHT_W-1:0]   light_t;

  localparam light_t LIGHT_RED   = 2'd0;
  localparam light_t LIGHT_AMBER = 2'd1;
  localparam light_t LIGHT_GREEN = 2'd2;

  localparam cfg_idx_t CFG_AMBER_TICKS = 2'd0;
  localparam cfg_idx_t CFG_GREEN_TICKS = 2'd1;

  localparam ticks_t AMBER_TICKS_RESET = 16'd1000;
  localparam ticks_t GREEN_TICKS_RESET = 16'd4000;

endpackage
`default_nettype wire

FILE: rtl/two_road_traffic_light_controller.sv
// Crossing controller for a main road and a side road, cycling main green,
// main amber, side green, side amber.
// Input channel (in_valid / in_stall): one word per timer tick carrying the
// two pedestrian button pulses and the side-road car loop pulse.
// Output channel (out_valid / out_stall): one word per tick with the four
// light codes and the phase after that tick.
// Config port (cfg_we / cfg_index / cfg_wdata): index 0 sets the amber time,
// index 1 the green time, in ticks; other indexes are ignored. A new time
// takes effect at the next phase reload.
// The result of a tick is on the output in the cycle after the tick is
// accepted. Throughput: one tick per cycle while the receiver does not
// stall; the next-state logic is a single decrement, compare and priority
// select feeding the state registers; the lights decode from the phase register.
// Reset: main green with a full green countdown, no pending requests, no
// output word pending.
// When the receiver stalls a pending word, the output word holds and in_stall
// rises, so no further tick is taken until the pending word is delivered.
`default_nettype none
module two_road_traffic_light_controller #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire tlc_pkg::cfg_idx_t cfg_index,
  input  wire tlc_pkg::ticks_t   cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_main_button_press,
  input  wire logic              in_side_button_press,
  input  wire logic              in_loop_detect,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tlc_pkg::light_t        out_main_car_light,
  output tlc_pkg::light_t        out_side_car_light,
  output tlc_pkg::light_t        out_main_walk_light,
  output tlc_pkg::light_t        out_side_walk_light,
  output logic [1:0]             out_phase
);
  import tlc_pkg::*;

  localparam int LOAD_W = (TIMER_BITS > TICKS_W) ? TIMER_BITS : TICKS_W;

  typedef logic [TIMER_BITS-1:0] timer_t;

  typedef enum logic [1:0] {
    PH_MAIN_GREEN = 2'd0,
    PH_MAIN_AMBER = 2'd1,
    PH_SIDE_GREEN = 2'd2,
    PH_SIDE_AMBER = 2'd3
  } phase_t;

  function automatic timer_t timer_load(input ticks_t ticks);
    logic [LOAD_W-1:0] ext;
    logic [LOAD_W-1:0] maxv;
    begin
      ext  = LOAD_W'(ticks);
      maxv = LOAD_W'({TIMER_BITS{1'b1}});
      timer_load = (ext > maxv) ? {TIMER_BITS{1'b1}} : ext[TIMER_BITS-1:0];
    end
  endfunction

  ticks_t amber_ticks_r;
  ticks_t green_ticks_r;
  phase_t phase_r, phase_nxt;
  timer_t time_left_r, time_left_nxt;
  logic   main_req_r, main_req_nxt;
  logic   side_req_r, side_req_nxt;
  logic   loop_req_r, loop_req_nxt;
  logic   out_valid_r;

  logic   in_accept;
  logic   main_req, side_req, loop_req;
  timer_t time_dec;
  logic   expired;
  timer_t amber_load, green_load;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  assign amber_load = timer_load(amber_ticks_r);
  assign green_load = timer_load(green_ticks_r);

  always_comb begin
    main_req = main_req_r || in_main_button_press;
    side_req = side_req_r || in_side_button_press;
    loop_req = loop_req_r || in_loop_detect;
    time_dec = (time_left_r != '0) ? time_left_r - timer_t'(1) : '0;
    expired  = (time_dec == '0);

    phase_nxt     = phase_r;
    time_left_nxt = time_dec;
    main_req_nxt  = main_req;
    side_req_nxt  = side_req;
    loop_req_nxt  = loop_req;

    unique case (phase_r)
      PH_MAIN_GREEN: begin
        if (expired) begin
          if (main_req) begin
            main_req_nxt  = 1'b0;
            phase_nxt     = PH_MAIN_AMBER;
            time_left_nxt = amber_load;
          end else if (loop_req) begin
            loop_req_nxt  = 1'b0;
            phase_nxt     = PH_MAIN_AMBER;
            time_left_nxt = amber_load;
          end
        end else if (side_req) begin
          side_req_nxt  = 1'b0;
          time_left_nxt = green_load;
        end
      end
      PH_MAIN_AMBER: begin
        if (expired) begin
          phase_nxt     = PH_SIDE_GREEN;
          time_left_nxt = green_load;
        end else if (side_req) begin
          side_req_nxt  = 1'b0;
          time_left_nxt = amber_load;
        end else if (loop_req) begin
          loop_req_nxt  = 1'b0;
          time_left_nxt = amber_load;
        end else if (main_req) begin
          main_req_nxt  = 1'b0;
          time_left_nxt = amber_load;
        end
      end
      PH_SIDE_GREEN: begin
        if (expired) begin
          phase_nxt     = PH_SIDE_AMBER;
          time_left_nxt = amber_load;
        end else if (loop_req) begin
          loop_req_nxt  = 1'b0;
          time_left_nxt = green_load;
        end else if (main_req) begin
          main_req_nxt  = 1'b0;
          time_left_nxt = green_load;
        end
      end
      PH_SIDE_AMBER: begin
        if (expired) begin
          phase_nxt     = PH_MAIN_GREEN;
          time_left_nxt = green_load;
        end else if (side_req) begin
          side_req_nxt  = 1'b0;
          time_left_nxt = amber_load;
        end else if (main_req) begin
          main_req_nxt  = 1'b0;
          time_left_nxt = amber_load;
        end else if (loop_req) begin
          loop_req_nxt  = 1'b0;
          time_left_nxt = amber_load;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amber_ticks_r <= AMBER_TICKS_RESET;
      green_ticks_r <= GREEN_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AMBER_TICKS: amber_ticks_r <= cfg_wdata;
        CFG_GREEN_TICKS: green_ticks_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAIN_GREEN;
      time_left_r <= timer_load(GREEN_TICKS_RESET);
      main_req_r  <= 1'b0;
      side_req_r  <= 1'b0;
      loop_req_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r     <= phase_nxt;
        time_left_r <= time_left_nxt;
        main_req_r  <= main_req_nxt;
        side_req_r  <= side_req_nxt;
        loop_req_r  <= loop_req_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    out_main_car_light  = LIGHT_RED;
    out_side_car_light  = LIGHT_RED;
    out_main_walk_light = LIGHT_RED;
    out_side_walk_light = LIGHT_RED;
    unique case (phase_r)
      PH_MAIN_GREEN: begin
        out_main_car_light  = LIGHT_GREEN;
        out_side_walk_light = LIGHT_GREEN;
      end
      PH_MAIN_AMBER: begin
        out_main_car_light  = LIGHT_AMBER;
        out_side_walk_light = LIGHT_GREEN;
      end
      PH_SIDE_GREEN: begin
        out_side_car_light  = LIGHT_GREEN;
        out_main_walk_light = LIGHT_GREEN;
      end
      PH_SIDE_AMBER: begin
        out_side_car_light  = LIGHT_AMBER;
        out_main_walk_light = LIGHT_GREEN;
      end
      default: begin
        out_main_car_light = LIGHT_RED;
      end
    endcase
  end

  assign out_phase = phase_r;

  a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted tick produced no output word");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> ($stable(phase_r) && $stable(time_left_r)
                    && $stable(main_req_r) && $stable(side_req_r)
                    && $stable(loop_req_r)))
    else $error("controller state moved without an accepted tick");

  a_phase_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (phase_r == $past(phase_r)
                   || phase_r == phase_t'($past(phase_r) + 2'd1)))
    else $error("phase skipped a step");

  a_no_early_change: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && time_left_r > timer_t'(1)) |=> phase_r == $past(phase_r))
    else $error("phase changed before the countdown ran out");

endmodule
`default_nettype wire

FILE: bench/two_road_traffic_light_controller_tb.sv
module two_road_traffic_light_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlc_pkg::*;

  typedef enum logic [1:0] {MAIN_GREEN, MAIN_AMBER, SIDE_GREEN, SIDE_AMBER} phase_t;

  typedef struct packed {
    light_t main_car;
    light_t side_car;
    light_t main_walk;
    light_t side_walk;
    phase_t phase;
  } crossing_word_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [2:0]     presses;
    cfg_idx_t       idx;
    ticks_t         value;
    logic           typed;
    crossing_word_t want;
  } plan_row_t;

  localparam cfg_idx_t CFG_SPARE_2 = 2'd2;
  localparam cfg_idx_t CFG_SPARE_3 = 2'd3;
  localparam ticks_t TICKS_MAX = 16'hFFFF;
  localparam crossing_word_t AT_MAIN_GREEN =
    '{LIGHT_GREEN, LIGHT_RED, LIGHT_RED, LIGHT_GREEN, MAIN_GREEN};

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  ticks_t cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic in_main_button_press;
  logic in_side_button_press;
  logic in_loop_detect;
  logic out_valid;
  logic out_stall = 1'b0;
  light_t out_main_car_light;
  light_t out_side_car_light;
  light_t out_main_walk_light;
  light_t out_side_walk_light;
  logic [1:0] out_phase;

  ticks_t amber_len;
  ticks_t green_len;
  ticks_t time_left;
  phase_t cur_phase;
  logic main_req;
  logic side_req;
  logic loop_req;
  crossing_word_t lights_due[$];
  int errors = 0;
  int sent = 0;
  int tx_max = 14;
  int rx_max = 14;
  int stall_run = 0;
  int words_seen = 0;
  int words_paced = 0;

  two_road_traffic_light_controller dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_main_button_press(in_main_button_press),
    .in_side_button_press(in_side_button_press),
    .in_loop_detect      (in_loop_detect),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_main_car_light  (out_main_car_light),
    .out_side_car_light  (out_side_car_light),
    .out_main_walk_light (out_main_walk_light),
    .out_side_walk_light (out_side_walk_light),
    .out_phase           (out_phase)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic crossing_word_t step_crossing(logic [2:0] presses);
    crossing_word_t w;
    logic expired;
    main_req |= presses[2];
    side_req |= presses[1];
    loop_req |= presses[0];
    if (time_left != '0) time_left = time_left - 1'b1;
    expired = (time_left == '0);
    case (cur_phase)
      MAIN_GREEN: begin
        if (expired && (main_req || loop_req)) begin
          if (main_req) main_req = 1'b0;
          else loop_req = 1'b0;
          cur_phase = MAIN_AMBER;
          time_left = amber_len;
        end else if (!expired && side_req) begin
          side_req = 1'b0;
          time_left = green_len;
        end
      end
      MAIN_AMBER: begin
        if (expired) begin
          cur_phase = SIDE_GREEN;
          time_left = green_len;
        end else if (side_req || loop_req || main_req) begin
          if (side_req) side_req = 1'b0;
          else if (loop_req) loop_req = 1'b0;
          else main_req = 1'b0;
          time_left = amber_len;
        end
      end
      SIDE_GREEN: begin
        if (expired) begin
          cur_phase = SIDE_AMBER;
          time_left = amber_len;
        end else if (loop_req || main_req) begin
          if (loop_req) loop_req = 1'b0;
          else main_req = 1'b0;
          time_left = green_len;
        end
      end
      default: begin
        if (expired) begin
          cur_phase = MAIN_GREEN;
          time_left = green_len;
        end else if (side_req || main_req || loop_req) begin
          if (side_req) side_req = 1'b0;
          else if (main_req) main_req = 1'b0;
          else loop_req = 1'b0;
          time_left = amber_len;
        end
      end
    endcase
    w.phase = cur_phase;
    w.main_car = (cur_phase == MAIN_GREEN) ? LIGHT_GREEN :
                 (cur_phase == MAIN_AMBER) ? LIGHT_AMBER : LIGHT_RED;
    w.side_car = (cur_phase == SIDE_GREEN) ? LIGHT_GREEN :
                 (cur_phase == SIDE_AMBER) ? LIGHT_AMBER : LIGHT_RED;
    w.main_walk = (cur_phase == SIDE_GREEN || cur_phase == SIDE_AMBER) ? LIGHT_GREEN : LIGHT_RED;
    w.side_walk = (cur_phase == MAIN_GREEN || cur_phase == MAIN_AMBER) ? LIGHT_GREEN : LIGHT_RED;
    return w;
  endfunction

  function automatic plan_row_t tick_row(logic [2:0] presses);
    return '{ROW_TICK, presses, CFG_AMBER_TICKS, '0, 1'b0, AT_MAIN_GREEN};
  endfunction

  function automatic plan_row_t write_row(cfg_idx_t idx, ticks_t value);
    return '{ROW_WRITE, 3'b000, idx, value, 1'b0, AT_MAIN_GREEN};
  endfunction

  function automatic ticks_t pick_ticks(int short_max);
    case ($urandom_range(0, 11))
      0: return TICKS_MAX;
      1: return '0;
      2: return 16'd1;
      default: return ticks_t'($urandom_range(0, short_max));
    endcase
  endfunction

  task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic send_tick(logic [2:0] presses, logic typed, crossing_word_t want);
    int gap;
    crossing_word_t got;
    gap = $urandom_range(0, tx_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_main_button_press, in_side_button_press, in_loop_detect} <= presses;
    do @(posedge clk); while (in_stall);
    got = step_crossing(presses);
    lights_due.push_back(typed ? want : got);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (lights_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, ticks_t value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_AMBER_TICKS: amber_len = value;
      CFG_GREEN_TICKS: green_len = value;
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    if (words_paced != words_seen) begin
      words_paced = words_seen;
      stall_run = $urandom_range(0, rx_max);
    end
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    crossing_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (lights_due.size() == 0) begin
        $display("%0t: phase expected none got %0d", $time, out_phase);
        errors++;
      end else begin
        want = lights_due.pop_front();
        check_field("main car light", want.main_car, out_main_car_light);
        check_field("side car light", want.side_car, out_side_car_light);
        check_field("main walk light", want.main_walk, out_main_walk_light);
        check_field("side walk light", want.side_walk, out_side_walk_light);
        check_field("phase", want.phase, out_phase);
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    int burst;
    int pct;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_AMBER_TICKS;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_main_button_press = 1'b0;
    in_side_button_press = 1'b0;
    in_loop_detect = 1'b0;
    amber_len = AMBER_TICKS_RESET;
    green_len = GREEN_TICKS_RESET;
    time_left = GREEN_TICKS_RESET;
    cur_phase = MAIN_GREEN;
    main_req = 1'b0;
    side_req = 1'b0;
    loop_req = 1'b0;

    plan.push_back('{ROW_TICK, 3'b000, CFG_AMBER_TICKS, '0, 1'b1, AT_MAIN_GREEN});
    plan.push_back('{ROW_TICK, 3'b111, CFG_AMBER_TICKS, '0, 1'b1, AT_MAIN_GREEN});
    plan.push_back(write_row(CFG_GREEN_TICKS, 16'd1));
    plan.push_back(write_row(CFG_AMBER_TICKS, 16'd2));
    plan.push_back(tick_row(3'b010));
    plan.push_back(tick_row(3'b000));
    plan.push_back(tick_row(3'b000));
    plan.push_back(tick_row(3'b000));
    plan.push_back(tick_row(3'b000));
    plan.push_back(tick_row(3'b100));
    plan.push_back(tick_row(3'b000));
    plan.push_back(tick_row(3'b000));
    plan.push_back(tick_row(3'b000));
    plan.push_back(tick_row(3'b000));
    plan.push_back(tick_row(3'b010));
    plan.push_back(tick_row(3'b000));
    plan.push_back(tick_row(3'b001));
    plan.push_back(write_row(CFG_AMBER_TICKS, 16'd0));
    plan.push_back(write_row(CFG_GREEN_TICKS, 16'd0));
    plan.push_back(tick_row(3'b011));
    plan.push_back(tick_row(3'b110));
    plan.push_back(tick_row(3'b101));
    plan.push_back(tick_row(3'b000));
    plan.push_back(tick_row(3'b111));
    plan.push_back(write_row(CFG_SPARE_2, 16'd7));
    plan.push_back(write_row(CFG_SPARE_3, 16'd9));
    plan.push_back(write_row(CFG_AMBER_TICKS, TICKS_MAX));
    plan.push_back(write_row(CFG_GREEN_TICKS, TICKS_MAX));
    plan.push_back(tick_row(3'b111));
    plan.push_back(tick_row(3'b000));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_tick(plan[i].presses, plan[i].typed, plan[i].want);
      end
    end

    while (sent < 2000) begin
      drain();
      if ($urandom_range(0, 3) != 0) write_reg(CFG_AMBER_TICKS, pick_ticks(5));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_GREEN_TICKS, pick_ticks(9));
      if ($urandom_range(0, 15) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, ticks_t'($urandom));
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      case ($urandom_range(0, 2))
        0: pct = 4;
        1: pct = 25;
        default: pct = 60;
      endcase
      burst = $urandom_range(20, 120);
      repeat (burst) begin
        if ($urandom_range(0, 63) == 0) drain();
        send_tick({($urandom_range(0, 99) < pct), ($urandom_range(0, 99) < pct),
                   ($urandom_range(0, 99) < pct)}, 1'b0, AT_MAIN_GREEN);
      end
    end

    drain();
    repeat (5) @(negedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
